@@ hdl/csvesc_pkg.sv @@
// shared types for the csv escape field splitter
package csvesc_pkg;

  localparam int MaxRes = 5;
  localparam int CntW   = $clog2(MaxRes + 1);
  localparam int IdxW   = $clog2(MaxRes);

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [CntW-1:0]  count;
    res_t [MaxRes-1:0] ent;
  } bundle_t;

endpackage

@@ hdl/csvesc_parse.sv @@
// parser state and per-byte result decode
module csvesc_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_eos,
  output csvesc_pkg::bundle_t bundle
);
  import csvesc_pkg::*;

  typedef enum logic [2:0] {
    M_ROW    = 3'd0,
    M_FIELD  = 3'd1,
    M_QUOTED = 3'd2,
    M_ESC    = 3'd3,
    M_HEX1   = 3'd4,
    M_HEX2   = 3'd5,
    M_OCT2   = 3'd6,
    M_OCT3   = 3'd7
  } mode_t;

  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChBsl   = 8'h5c;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch7     = 8'h37;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= Ch0 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= Ch0 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= Ch0 && c <= Ch7;
  endfunction

  // {hit, value}
  function automatic logic [8:0] letter_esc(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h72:   r = {1'b1, 8'd13};
      8'h6e:   r = {1'b1, 8'd10};
      8'h74:   r = {1'b1, 8'd9};
      ChBsl:   r = {1'b1, ChBsl};
      ChSq:    r = {1'b1, ChSq};
      ChDq:    r = {1'b1, ChDq};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic res_t mk(input logic [7:0] d, input kind_t k);
    res_t r;
    r.data = d;
    r.kind = k;
    return r;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic       qs_r, qs_nxt;
  logic [7:0] hf_r, hf_nxt;
  logic [7:0] hs_r, hs_nxt;
  logic       acr_r, acr_nxt;

  logic [8:0] lesc;
  logic [7:0] qc;
  logic       row_in;
  res_t       row_mark;

  assign lesc     = letter_esc(in_byte);
  assign qc       = qs_r ? ChSq : ChDq;
  assign row_mark = mk(8'd0, KIND_ROW);
  // unquoted handling is shared by row start and unquoted field
  assign row_in   = (mode_r == M_ROW);

  always_comb begin
    mode_nxt     = mode_r;
    qs_nxt       = qs_r;
    hf_nxt       = hf_r;
    hs_nxt       = hs_r;
    acr_nxt      = acr_r;
    bundle.count = '0;
    bundle.ent   = '0;
    unique case (mode_r)
      M_ROW, M_FIELD: begin
        if (row_in && (in_eos || (acr_r && in_byte == ChLf))) begin
          acr_nxt = 1'b0;
        end else begin
          if (row_in) acr_nxt = 1'b0;
          priority if (in_eos) begin
            bundle.ent[0] = row_mark;
            bundle.count  = CntW'(1);
            mode_nxt      = M_ROW;
          end else if (in_byte == ChComma) begin
            bundle.ent[0] = mk(8'd0, KIND_FIELD);
            bundle.count  = CntW'(1);
            mode_nxt      = M_FIELD;
          end else if (in_byte == ChCr) begin
            bundle.ent[0] = row_mark;
            bundle.count  = CntW'(1);
            mode_nxt      = M_ROW;
            acr_nxt       = 1'b1;
          end else if (in_byte == ChLf) begin
            bundle.ent[0] = row_mark;
            bundle.count  = CntW'(1);
            mode_nxt      = M_ROW;
          end else if (in_byte == ChDq || in_byte == ChSq) begin
            qs_nxt   = (in_byte == ChSq);
            mode_nxt = M_QUOTED;
          end else begin
            bundle.ent[0] = mk(in_byte, KIND_BYTE);
            bundle.count  = CntW'(1);
            mode_nxt      = M_FIELD;
          end
        end
      end
      M_QUOTED: begin
        priority if (in_eos) begin
          bundle.ent[0] = row_mark;
          bundle.count  = CntW'(1);
          mode_nxt      = M_ROW;
        end else if (in_byte == qc) begin
          mode_nxt = M_FIELD;
        end else if (in_byte == ChBsl) begin
          mode_nxt = M_ESC;
        end else begin
          bundle.ent[0] = mk(in_byte, KIND_BYTE);
          bundle.count  = CntW'(1);
        end
      end
      M_ESC: begin
        priority if (in_eos) begin
          bundle.ent[0] = mk(ChBsl, KIND_BYTE);
          bundle.ent[1] = row_mark;
          bundle.count  = CntW'(2);
          mode_nxt      = M_ROW;
        end else if (lesc[8]) begin
          bundle.ent[0] = mk(lesc[7:0], KIND_BYTE);
          bundle.count  = CntW'(1);
          mode_nxt      = M_QUOTED;
        end else if (in_byte == ChX) begin
          mode_nxt = M_HEX1;
        end else if (is_oct(in_byte)) begin
          hf_nxt   = in_byte;
          mode_nxt = M_OCT2;
        end else begin
          bundle.ent[0] = mk(ChBsl, KIND_BYTE);
          bundle.ent[1] = mk(in_byte, KIND_BYTE);
          bundle.count  = CntW'(2);
          mode_nxt      = M_QUOTED;
        end
      end
      M_HEX1: begin
        if (!in_eos && is_hex(in_byte)) begin
          hf_nxt   = in_byte;
          mode_nxt = M_HEX2;
        end else begin
          bundle.ent[0] = mk(ChBsl, KIND_BYTE);
          bundle.ent[1] = mk(ChX, KIND_BYTE);
          bundle.ent[2] = in_eos ? row_mark : mk(in_byte, KIND_BYTE);
          bundle.count  = CntW'(3);
          mode_nxt      = in_eos ? M_ROW : M_QUOTED;
        end
      end
      M_HEX2: begin
        if (!in_eos && is_hex(in_byte)) begin
          bundle.ent[0] = mk({hex_val(hf_r), hex_val(in_byte)}, KIND_BYTE);
          bundle.count  = CntW'(1);
          mode_nxt      = M_QUOTED;
        end else begin
          bundle.ent[0] = mk(ChBsl, KIND_BYTE);
          bundle.ent[1] = mk(ChX, KIND_BYTE);
          bundle.ent[2] = mk(hf_r, KIND_BYTE);
          bundle.ent[3] = in_eos ? row_mark : mk(in_byte, KIND_BYTE);
          bundle.count  = CntW'(4);
          mode_nxt      = in_eos ? M_ROW : M_QUOTED;
        end
      end
      M_OCT2: begin
        if (!in_eos && is_oct(in_byte)) begin
          hs_nxt   = in_byte;
          mode_nxt = M_OCT3;
        end else begin
          bundle.ent[0] = mk(ChBsl, KIND_BYTE);
          bundle.ent[1] = mk(hf_r, KIND_BYTE);
          bundle.ent[2] = in_eos ? row_mark : mk(in_byte, KIND_BYTE);
          bundle.count  = CntW'(3);
          mode_nxt      = in_eos ? M_ROW : M_QUOTED;
        end
      end
      M_OCT3: begin
        if (!in_eos && is_oct(in_byte)) begin
          // top digit keeps only two bits after truncation to a byte
          bundle.ent[0] = mk({hf_r[1:0], hs_r[2:0], in_byte[2:0]}, KIND_BYTE);
          bundle.count  = CntW'(1);
          mode_nxt      = M_QUOTED;
        end else begin
          bundle.ent[0] = mk(ChBsl, KIND_BYTE);
          bundle.ent[1] = mk(hf_r, KIND_BYTE);
          bundle.ent[2] = mk(hs_r, KIND_BYTE);
          bundle.ent[3] = in_eos ? row_mark : mk(in_byte, KIND_BYTE);
          bundle.count  = CntW'(4);
          mode_nxt      = in_eos ? M_ROW : M_QUOTED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_ROW;
      qs_r   <= 1'b0;
      hf_r   <= 8'd0;
      hs_r   <= 8'd0;
      acr_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      qs_r   <= qs_nxt;
      hf_r   <= hf_nxt;
      hs_r   <= hs_nxt;
      acr_r  <= acr_nxt;
    end
  end

endmodule

@@ hdl/csvesc_ser.sv @@
// result register with skid slot, drains one result per transfer
module csvesc_ser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  csvesc_pkg::bundle_t push_bundle,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic [1:0]          out_kind,
  output logic                out_last
);
  import csvesc_pkg::*;

  bundle_t         ob_r, sk_r;
  logic            ob_valid_r, sk_valid_r;
  logic [IdxW-1:0] idx_r;
  logic            take, at_last, ob_free;
  res_t            cur;

  assign cur       = ob_r.ent[idx_r];
  assign at_last   = (CntW'(idx_r) == ob_r.count - CntW'(1));
  assign take      = ob_valid_r && !out_stall;
  assign ob_free   = !ob_valid_r || (take && at_last);
  assign full      = sk_valid_r;
  assign out_valid = ob_valid_r;
  assign out_byte  = cur.data;
  assign out_kind  = cur.kind;
  assign out_last  = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      sk_valid_r <= 1'b0;
      idx_r      <= '0;
    end else if (ob_free) begin
      idx_r <= '0;
      if (sk_valid_r) begin
        ob_r       <= sk_r;
        ob_valid_r <= 1'b1;
        sk_valid_r <= 1'b0;
      end else begin
        ob_valid_r <= push;
        if (push) ob_r <= push_bundle;
      end
    end else begin
      if (take) idx_r <= idx_r + IdxW'(1);
      // result register busy: park the new bundle in the skid slot
      if (push) begin
        sk_r       <= push_bundle;
        sk_valid_r <= 1'b1;
      end
    end
  end

  a_skid_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> ob_valid_r)
    else $error("skid slot filled while result register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> !push)
    else $error("bundle pushed into a full skid slot");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ob_valid_r |-> (ob_r.count != '0 && CntW'(idx_r) < ob_r.count))
    else $error("result index outside bundle");

  a_stall_holds_index: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_valid_r && out_stall) |=> $stable(idx_r))
    else $error("result index moved during a stall");

endmodule

@@ hdl/csv_escape_field_splitter_core.sv @@
// top level of the csv field splitter with c escape decoding
//
// input channel: one raw stream byte per transfer on in_byte, or an end of
// stream mark with in_end_of_stream high (in_byte then ignored).
// result channel: decoded field content bytes (out_kind 0), end of field
// marks (1) and end of field and row marks (2); out_byte is 0 on marks.
// out_last flags the final result caused by one input transfer. An input
// may cause no result at all (quotes, backslash, held escape digits).
// an input's results are registered before they are offered. throughput:
// one input per cycle while out_stall is low and each input yields at most
// one result; an input with n results holds the result register until all
// n are taken (n up to 4, only escapes emitted literally give over two).
// a one-bundle skid slot sits between the parser and the result register,
// so in_stall rises only once the result register and the slot are full.
// reset (synchronous, rst_n low) returns the parser to row start with no
// pending escape and empties both result stages.
module csv_escape_field_splitter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);
  import csvesc_pkg::*;

  logic    accept, full, push;
  bundle_t bundle;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push     = accept && (bundle.count != '0);

  csvesc_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_byte(in_byte),
    .in_eos (in_end_of_stream),
    .bundle (bundle)
  );

  csvesc_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_bundle(bundle),
    .full       (full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .out_last   (out_last)
  );

endmodule
